// ===== rtl/core/sorted_table_search_insert_delete_top_defines.svh =====
// Assertion macros for the sorted record table.
// Used by sorted_table_search_insert_delete_top; expects clk_i and rst_ni in scope.
`ifndef SORTED_TABLE_SEARCH_INSERT_DELETE_TOP_DEFINES_SVH
`define SORTED_TABLE_SEARCH_INSERT_DELETE_TOP_DEFINES_SVH

// Consequence checked in the same cycle as the antecedent.
`define STSID_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequence checked in the cycle after the antecedent.
`define STSID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/stsid_pkg.sv =====
// Shared types and constants for the sorted record table.
// No dependencies; used by stsid_search and the top level.
`timescale 1ns / 1ps

package stsid_pkg;

  localparam int DEPTH_DEFAULT = 32;
  localparam int KEY_W         = 64;
  localparam int VAL_W         = 64;
  localparam int POS_W         = 6;
  localparam int STATUS_W      = 3;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } record_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_FOUND     = 3'd0,
    STAT_INSERTED  = 3'd1,
    STAT_DELETED   = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_FULL      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT_UP,
    ST_SHIFT_DN
  } state_e;

  // Status of the binary search unit toward the control logic.
  typedef struct packed {
    logic rd_req;
    logic done;
    logic hit;
  } srch_stat_t;

endpackage

// ===== rtl/core/stsid_search.sv =====
// Binary search sequencer: keeps the lo/hi bounds and issues a probe, then waits for its read data before the next.
// Depends on stsid_pkg; the probe memory lives in the top level.
`timescale 1ns / 1ps

module stsid_search #(
  parameter int DEPTH = stsid_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [$clog2(DEPTH+1)-1:0]    count_i,
  input  logic [stsid_pkg::KEY_W-1:0]   key_i,
  input  logic [stsid_pkg::KEY_W-1:0]   probe_key_i,
  output stsid_pkg::srch_stat_t         stat_o,
  output logic [$clog2(DEPTH)-1:0]      mid_o,
  output logic [$clog2(DEPTH+1)-1:0]    pos_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [CW-1:0] lo_q, hi_q;
  logic [CW-1:0] mid_full;
  logic [AW-1:0] mid_q;
  logic          active_q, wait_q;
  logic          open_range;
  logic          key_eq;

  assign mid_full   = lo_q + ((hi_q - lo_q) >> 1);
  assign mid_o      = mid_full[AW-1:0];
  assign open_range = (lo_q < hi_q);
  assign key_eq     = (probe_key_i == key_i);

  always_comb begin
    stat_o.rd_req = active_q && !wait_q && open_range;
    stat_o.done   = active_q && ((!wait_q && !open_range) || (wait_q && key_eq));
    stat_o.hit    = active_q && wait_q && key_eq;
    pos_o         = stat_o.hit ? CW'(mid_q) : lo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q     <= '0;
      hi_q     <= '0;
      mid_q    <= '0;
      active_q <= 1'b0;
      wait_q   <= 1'b0;
    end else if (start_i) begin
      lo_q     <= '0;
      hi_q     <= count_i;
      active_q <= 1'b1;
      wait_q   <= 1'b0;
    end else if (active_q) begin
      if (!wait_q) begin
        if (open_range) begin
          mid_q  <= mid_o;
          wait_q <= 1'b1;
        end else begin
          active_q <= 1'b0;
        end
      end else begin
        wait_q <= 1'b0;
        if (key_eq) begin
          active_q <= 1'b0;
        end else if (key_i < probe_key_i) begin
          hi_q <= CW'(mid_q);
        end else begin
          lo_q <= CW'(mid_q) + 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/sorted_table_search_insert_delete_top.sv =====
// Sorted record table: lookup-or-insert and delete by key; uses stsid_pkg and stsid_search.
// Busy covers a search of P probes, P <= clog2(DEPTH+1), then the record moves, if any:
// an insert moves the m records above its point and writes the new one; a delete moves the m above the hit.
// done_o goes high in the same cycle in which busy falls.
// Throughput: one transaction at a time; the next can be accepted at the edge ending done_o.
// Reset clears the record count; the memory is not cleared. The receiver cannot stall results.
`timescale 1ns / 1ps
`include "sorted_table_search_insert_delete_top_defines.svh"

module sorted_table_search_insert_delete_top #(
  parameter int DEPTH = stsid_pkg::DEPTH_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             req_type_i,
  input  logic [stsid_pkg::KEY_W-1:0]      key_i,
  input  logic [stsid_pkg::VAL_W-1:0]      value_i,
  output logic                             done_o,
  output logic [stsid_pkg::STATUS_W-1:0]   status_o,
  output logic [stsid_pkg::POS_W-1:0]      position_o,
  output logic [stsid_pkg::KEY_W-1:0]      rec_key_o,
  output logic [stsid_pkg::VAL_W-1:0]      rec_value_o,
  output logic [stsid_pkg::POS_W-1:0]      fill_count_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);
  localparam int PW = stsid_pkg::POS_W;

  // Control state.
  stsid_pkg::state_e state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     pos_q, pos_d;
  logic [CW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]     wr_addr_q, wr_addr_d;
  logic              pend_q, pend_d;

  // Latched request and the record taken out by a delete.
  logic                        del_q;
  logic [stsid_pkg::KEY_W-1:0] key_q;
  logic [stsid_pkg::VAL_W-1:0] value_q;
  stsid_pkg::record_t          rec_q, rec_d;

  // Result registers.
  logic                        done_q, done_d;
  stsid_pkg::status_e          status_q, status_d;
  logic [PW-1:0]               position_q, position_d;
  logic [stsid_pkg::KEY_W-1:0] rkey_q, rkey_d;
  logic [stsid_pkg::VAL_W-1:0] rval_q, rval_d;
  logic [PW-1:0]               fill_q, fill_d;

  // Record memory: one write and one registered read per cycle.
  stsid_pkg::record_t mem [DEPTH];
  stsid_pkg::record_t mem_rdata_q;
  stsid_pkg::record_t mem_wdata;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;

  // Search unit.
  stsid_pkg::srch_stat_t srch_stat;
  logic [AW-1:0]         srch_mid;
  logic [CW-1:0]         srch_pos;
  logic                  accept;

  assign accept = start && (state_q == stsid_pkg::ST_IDLE);
  assign busy   = (state_q != stsid_pkg::ST_IDLE);

  stsid_search #(
    .DEPTH(DEPTH)
  ) u_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .count_i    (count_q),
    .key_i      (key_q),
    .probe_key_i(mem_rdata_q.key),
    .stat_o     (srch_stat),
    .mid_o      (srch_mid),
    .pos_o      (srch_pos)
  );

  // Sequencer. A search runs first; an insert then moves the records above the
  // insertion point up by one, from the top down, and a delete moves the records
  // above the hit down by one, from the bottom up. Each move reads a record in one
  // cycle and writes it in the next, overlapped with the following read, so the
  // read and write addresses of one cycle never coincide.
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    pos_d      = pos_q;
    rd_ptr_d   = rd_ptr_q;
    wr_addr_d  = wr_addr_q;
    pend_d     = pend_q;
    rec_d      = rec_q;
    done_d     = 1'b0;
    status_d   = status_q;
    position_d = position_q;
    rkey_d     = rkey_q;
    rval_d     = rval_q;
    fill_d     = fill_q;
    mem_we     = 1'b0;
    mem_waddr  = wr_addr_q;
    mem_wdata  = mem_rdata_q;
    mem_re     = 1'b0;
    mem_raddr  = srch_mid;

    case (state_q)
      stsid_pkg::ST_IDLE: begin
        if (start) begin
          state_d = stsid_pkg::ST_SEARCH;
        end
      end

      stsid_pkg::ST_SEARCH: begin
        mem_re    = srch_stat.rd_req;
        mem_raddr = srch_mid;
        if (srch_stat.done) begin
          if (!del_q) begin
            if (srch_stat.hit) begin
              done_d     = 1'b1;
              status_d   = stsid_pkg::STAT_FOUND;
              position_d = PW'(srch_pos);
              rkey_d     = mem_rdata_q.key;
              rval_d     = mem_rdata_q.value;
              fill_d     = PW'(count_q);
              state_d    = stsid_pkg::ST_IDLE;
            end else if (count_q == CW'(DEPTH)) begin
              done_d     = 1'b1;
              status_d   = stsid_pkg::STAT_FULL;
              position_d = PW'(srch_pos);
              rkey_d     = key_q;
              rval_d     = value_q;
              fill_d     = PW'(count_q);
              state_d    = stsid_pkg::ST_IDLE;
            end else begin
              pos_d    = srch_pos;
              rd_ptr_d = count_q;
              pend_d   = 1'b0;
              state_d  = stsid_pkg::ST_SHIFT_UP;
            end
          end else begin
            if (!srch_stat.hit) begin
              done_d     = 1'b1;
              status_d   = stsid_pkg::STAT_NOT_FOUND;
              position_d = '0;
              rkey_d     = key_q;
              rval_d     = '0;
              fill_d     = PW'(count_q);
              state_d    = stsid_pkg::ST_IDLE;
            end else begin
              rec_d    = mem_rdata_q;
              pos_d    = srch_pos;
              rd_ptr_d = srch_pos + 1'b1;
              pend_d   = 1'b0;
              state_d  = stsid_pkg::ST_SHIFT_DN;
            end
          end
        end
      end

      stsid_pkg::ST_SHIFT_UP: begin
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = wr_addr_q;
          mem_wdata = mem_rdata_q;
        end
        if (rd_ptr_q > pos_q) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(rd_ptr_q - 1'b1);
          wr_addr_d = AW'(rd_ptr_q);
          pend_d    = 1'b1;
          rd_ptr_d  = rd_ptr_q - 1'b1;
        end else if (pend_q) begin
          // The last move uses the write port this cycle; the new record goes next.
          pend_d = 1'b0;
        end else begin
          mem_we          = 1'b1;
          mem_waddr       = AW'(pos_q);
          mem_wdata.key   = key_q;
          mem_wdata.value = value_q;
          count_d         = count_q + 1'b1;
          done_d          = 1'b1;
          status_d        = stsid_pkg::STAT_INSERTED;
          position_d      = PW'(pos_q);
          rkey_d          = key_q;
          rval_d          = value_q;
          fill_d          = PW'(count_q + 1'b1);
          state_d         = stsid_pkg::ST_IDLE;
        end
      end

      stsid_pkg::ST_SHIFT_DN: begin
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = wr_addr_q;
          mem_wdata = mem_rdata_q;
        end
        if (rd_ptr_q < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(rd_ptr_q);
          wr_addr_d = AW'(rd_ptr_q - 1'b1);
          pend_d    = 1'b1;
          rd_ptr_d  = rd_ptr_q + 1'b1;
        end else begin
          pend_d     = 1'b0;
          count_d    = count_q - 1'b1;
          done_d     = 1'b1;
          status_d   = stsid_pkg::STAT_DELETED;
          position_d = PW'(pos_q);
          rkey_d     = rec_q.key;
          rval_d     = rec_q.value;
          fill_d     = PW'(count_q - 1'b1);
          state_d    = stsid_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = stsid_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= stsid_pkg::ST_IDLE;
      count_q   <= '0;
      pos_q     <= '0;
      rd_ptr_q  <= '0;
      wr_addr_q <= '0;
      pend_q    <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      pos_q     <= pos_d;
      rd_ptr_q  <= rd_ptr_d;
      wr_addr_q <= wr_addr_d;
      pend_q    <= pend_d;
      done_q    <= done_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      del_q   <= req_type_i;
      key_q   <= key_i;
      value_q <= value_i;
    end
    rec_q      <= rec_d;
    status_q   <= status_d;
    position_q <= position_d;
    rkey_q     <= rkey_d;
    rval_q     <= rval_d;
    fill_q     <= fill_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign position_o   = position_q;
  assign rec_key_o    = rkey_q;
  assign rec_value_o  = rval_q;
  assign fill_count_o = fill_q;

  // The record count never runs past the table size.
  `STSID_ASSERT_NOW(a_count_range, 1'b1, count_q <= CW'(DEPTH), "record count exceeds depth")
  // A record move is only ever pending while records are being shifted.
  `STSID_ASSERT_NOW(a_pend_in_shift, pend_q,
    (state_q == stsid_pkg::ST_SHIFT_UP || state_q == stsid_pkg::ST_SHIFT_DN),
    "record move pending outside a shift")
  // An insert result comes with the count raised by one.
  `STSID_ASSERT_NOW(a_insert_count,
    done_q && (status_q == stsid_pkg::STAT_INSERTED),
    count_q == CW'($past(count_q) + 1'b1), "insert did not raise the record count")
  // A delete result comes with the count lowered by one.
  `STSID_ASSERT_NOW(a_delete_count,
    done_q && (status_q == stsid_pkg::STAT_DELETED),
    count_q == CW'($past(count_q) - 1'b1), "delete did not lower the record count")

endmodule
